// File: hw/rtl/sfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, constants and helpers of the frame stack allocator.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int FIELD_W              = 17;
   localparam int FIELD_LIMIT          = 65536;
   localparam int MAX_STACK_BYTES_DEF  = 65536;
   localparam int ALIGN_BYTES          = 16;
   localparam int ALIGN_SHIFT          = $clog2(ALIGN_BYTES);
   localparam int HEADER_RAW_BYTES     = 8;
   localparam int HEADER_BYTES         =
      ((HEADER_RAW_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [FIELD_W-1:0] req_size;
      logic [FIELD_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [FIELD_W-1:0] payload_offset;
      logic [FIELD_W-1:0] top_offset;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic alloc;
      logic finish_free;
      logic hole_rd;
      logic hole_wr;
      logic walk_rd;
      logic walk_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic free_valid;
      logic free_is_top;
      logic walk_done;
   } ctl_status_type;

   function automatic logic [FIELD_W-1:0] align_down(input logic [FIELD_W-1:0] pos);
      return pos & ~FIELD_W'(ALIGN_BYTES - 1);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_ctrl
// Sequencer of the allocator: decodes a word, steps the hole walk and
// issues the result strobe.
// ----------------------------------------------------------------------------
module sfa_ctrl
   import sfa_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MARK,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (status.is_alloc) begin
               cmd.alloc    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!status.free_valid) begin
               cmd.finish_free = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else if (!status.free_is_top) begin
               cmd.hole_rd = 1'b1;
               state_in    = ST_MARK;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_WALK;
            end
         end
         ST_MARK: begin
            cmd.hole_wr     = 1'b1;
            cmd.finish_free = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      busy == (state_ff != ST_IDLE))
      else $error("busy does not match controller state");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word did not make the block busy");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

endmodule
`default_nettype wire

// File: hw/rtl/sfa_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_dpath
// Datapath of the allocator: top and end registers, header memory, the
// allocate arithmetic and one hop of the hole walk per cycle.
// ----------------------------------------------------------------------------
module sfa_dpath
   import sfa_pkg::*;
#(
   parameter int MAX_STACK_BYTES = MAX_STACK_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_data,
   input  wire logic               csr_we,
   input  wire logic [FIELD_W-1:0] csr_data,
   input  wire ctl_cmd_type        cmd,
   output ctl_status_type          status,
   output rsp_type                 rsp_data
);

   localparam int EFF_BYTES = (MAX_STACK_BYTES < FIELD_LIMIT) ? MAX_STACK_BYTES : FIELD_LIMIT;
   localparam int DEPTH     = EFF_BYTES / ALIGN_BYTES;
   localparam int AW        = $clog2(DEPTH);
   localparam logic [FIELD_W-1:0] CAP       = FIELD_W'(EFF_BYTES);
   localparam logic [FIELD_W-1:0] RESET_END = align_down(CAP);
   localparam logic [FIELD_W-1:0] HDR       = FIELD_W'(HEADER_BYTES);

   req_type            req_ff;
   logic [FIELD_W-1:0] top_ff, top_in;
   logic [FIELD_W-1:0] end_ff, end_in;
   logic [FIELD_W-1:0] pos_ff, pos_in;
   logic               first_ff;
   logic [FIELD_W-1:0] rd_ff;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [FIELD_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic [FIELD_W-1:0] hdr_mem_ff [DEPTH];

   logic [FIELD_W+1:0] room;
   logic               alloc_ok;
   logic [FIELD_W-1:0] avail, hdr_val, pay, fpos, csr_sat;
   logic [FIELD_W-1:0] hop_len, span, jump, final_pos;
   logic               walk_stop, walk_done;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_addr;
   logic [FIELD_W-1:0] mem_wd;

   always_comb begin
      room     = {2'b00, top_ff} - {2'b00, HDR} - {2'b00, req_ff.req_size};
      alloc_ok = !room[FIELD_W+1];
      avail    = align_down(room[FIELD_W-1:0]);
      hdr_val  = top_ff - avail;
      pay      = avail + HDR;
      fpos     = req_ff.free_offset - HDR;

      hop_len   = {rd_ff[FIELD_W-1:1], 1'b0};
      span      = end_ff - pos_ff;
      jump      = (hop_len == '0 || hop_len >= span) ? end_ff : pos_ff + hop_len;
      walk_stop = !first_ff && (!rd_ff[0] || hop_len == '0);
      walk_done = walk_stop || (jump == end_ff);
      final_pos = walk_stop ? pos_ff : jump;

      status.is_alloc    = (req_ff.cmd == CMD_ALLOC);
      status.free_valid  = (req_ff.free_offset >= HDR) && (fpos >= top_ff) &&
                           (fpos < end_ff) && (fpos[ALIGN_SHIFT-1:0] == '0);
      status.free_is_top = (fpos == top_ff);
      status.walk_done   = walk_done;

      csr_sat = (csr_data > CAP) ? CAP : csr_data;
   end

   always_comb begin
      mem_we = (cmd.alloc && alloc_ok) || cmd.hole_wr;
      mem_re = cmd.hole_rd || cmd.walk_rd || (cmd.walk_step && !walk_done);
      mem_wd = cmd.alloc ? hdr_val : (rd_ff | FIELD_W'(1));
      priority if (cmd.alloc) begin
         mem_addr = avail[ALIGN_SHIFT +: AW];
      end else if (cmd.hole_wr) begin
         mem_addr = pos_ff[ALIGN_SHIFT +: AW];
      end else if (cmd.walk_step) begin
         mem_addr = jump[ALIGN_SHIFT +: AW];
      end else begin
         mem_addr = fpos[ALIGN_SHIFT +: AW];
      end
   end

   always_comb begin
      top_in     = top_ff;
      end_in     = end_ff;
      pos_in     = pos_ff;
      rsp_ok_in  = rsp_ok_ff;
      rsp_pay_in = rsp_pay_ff;
      if (csr_we) begin
         end_in = align_down(csr_sat);
         top_in = align_down(csr_sat);
      end
      if (cmd.alloc) begin
         rsp_ok_in  = alloc_ok;
         rsp_pay_in = alloc_ok ? pay : '0;
         if (alloc_ok) begin
            top_in = avail;
         end
      end
      if (cmd.finish_free || (cmd.walk_step && walk_done)) begin
         rsp_ok_in  = 1'b1;
         rsp_pay_in = '0;
      end
      if (cmd.hole_rd || cmd.walk_rd) begin
         pos_in = fpos;
      end
      if (cmd.walk_step) begin
         pos_in = jump;
         if (walk_done) begin
            top_in = final_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= RESET_END;
         end_ff <= RESET_END;
      end else begin
         top_ff <= top_in;
         end_ff <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.walk_rd) begin
         first_ff <= 1'b1;
      end else if (cmd.walk_step) begin
         first_ff <= 1'b0;
      end
      pos_ff     <= pos_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem_ff[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= hdr_mem_ff[mem_addr];
      end
   end

   assign rsp_data.ok             = rsp_ok_ff;
   assign rsp_data.payload_offset = rsp_pay_ff;
   assign rsp_data.top_offset     = top_ff;

   a_top_below_end: assert property (@(posedge clock) disable iff (reset)
      top_ff <= end_ff)
      else $error("stack top above stack end");

   a_top_aligned: assert property (@(posedge clock) disable iff (reset)
      top_ff[ALIGN_SHIFT-1:0] == '0 && end_ff[ALIGN_SHIFT-1:0] == '0)
      else $error("stack top or end not aligned");

   a_alloc_moves_down: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc && alloc_ok && !csr_we) |=> (top_ff < $past(top_ff)))
      else $error("allocation did not lower the top");

endmodule
`default_nettype wire

// File: hw/rtl/stack_frame_allocator_with_holes_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_frame_allocator_with_holes_core
// Downward-growing frame stack allocator with deferred free of hole frames.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// rsp_data for exactly one cycle with rsp_valid, and the receiver cannot stall
// it. An allocate and a free that is ignored are finished in the execute
// state, and a free of a frame below the top reads its header and writes it
// back marked as a hole. A free of the top frame walks up over the hole frames
// above it, popping each, until the walk reaches the stack end or stops at a
// live frame; the walk makes one read of the single-port header memory per
// hop. The next word is taken in the cycle that shows the result. The header
// memory is not cleared after reset; a header that was never written reads as
// garbage. Writes to the stack size register are taken while the block is not
// busy and reset the top to the aligned stack end.
// ----------------------------------------------------------------------------
module stack_frame_allocator_with_holes_core
   import sfa_pkg::*;
#(
   parameter int MAX_STACK_BYTES = MAX_STACK_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [FIELD_W-1:0] csr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   assign csr_ready = !busy;

   sfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   sfa_dpath #(
      .MAX_STACK_BYTES (MAX_STACK_BYTES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
